// ===== hdl/jsd_pkg.sv =====
// Shared types, constants and helper functions for the job slot dispatch table.
package jsd_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int CFG_W    = 5;
  localparam int HANDLE_W = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_ASSIGN = 2'd1,
    FUNC_DONE   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NO_JOB    = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [HANDLE_W-1:0] job_handle;
  } jsd_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] assigned_handle;
    logic [3:0]          slot_index;
    logic [4:0]          pending_count;
    logic                table_full;
    logic                more_waiting;
    logic                all_done;
  } jsd_out_t;

  typedef struct packed {
    logic load;
    logic push;
    logic assign_job;
    logic capture;
    logic scan_start;
    logic scan_step;
    logic match_clear;
    logic fail;
    logic emit;
  } jsd_cmd_t;

  typedef struct packed {
    func_e func;
    logic  wait_found;
    logic  cand_found;
    logic  match;
    logic  out_free;
  } jsd_stat_t;

  function automatic logic [SLOT_W-1:0] lowest_idx(input logic [SLOTS-1:0] mask);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [CNT_W-1:0] popcount(input logic [SLOTS-1:0] mask);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cnt = cnt + CNT_W'(mask[i]);
    end
    return cnt;
  endfunction

endpackage

// ===== hdl/jsd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module jsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/jsd_ctrl.sv =====
// Controller state machine sequencing push, assign and done operations.
module jsd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jsd_pkg::jsd_stat_t stat_i,
  output jsd_pkg::jsd_cmd_t  cmd_o
);
  import jsd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_ASG_RD = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_CMP    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (stat_i.func)
          FUNC_PUSH: begin
            cmd_o.push = 1'b1;
            state_d    = ST_EMIT;
          end
          FUNC_ASSIGN: begin
            if (stat_i.wait_found) begin
              cmd_o.assign_job = 1'b1;
              state_d          = ST_ASG_RD;
            end else begin
              cmd_o.fail = 1'b1;
              state_d    = ST_EMIT;
            end
          end
          FUNC_DONE: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          default: begin
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_ASG_RD: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_SCAN: begin
        if (stat_i.cand_found) begin
          cmd_o.scan_step = 1'b1;
          state_d         = ST_CMP;
        end else begin
          cmd_o.fail = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_CMP: begin
        if (stat_i.match) begin
          cmd_o.match_clear = 1'b1;
          state_d           = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/jsd_dp.sv =====
// Datapath: slot marks, handle store, slot search, result and output register.
module jsd_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jsd_pkg::jsd_in_t           in_data_i,
  input  logic                       cfg_we_i,
  input  logic [jsd_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output jsd_pkg::jsd_out_t          out_data_o,
  input  jsd_pkg::jsd_cmd_t          cmd_i,
  output jsd_pkg::jsd_stat_t         stat_o
);
  import jsd_pkg::*;

  logic [CFG_W-1:0]    slots_q;
  logic [1:0]          func_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [SLOT_W-1:0]   slot_q;
  status_e             res_status_q;
  logic [HANDLE_W-1:0] assigned_q;
  logic [SLOTS-1:0]    pend_q, run_q, scan_q;
  jsd_out_t            out_q;
  logic                out_valid_q;

  logic [CNT_W-1:0]    n_eff;
  logic [SLOTS-1:0]    en_mask, free_mask, wait_mask;
  logic [SLOT_W-1:0]   free_idx, wait_idx, cand_idx;
  logic [SLOTS-1:0]    free_bit, wait_bit, cand_bit, slot_bit;
  logic                free_found;
  logic [CNT_W-1:0]    pend_cnt;
  logic                ram_we, ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [HANDLE_W-1:0] ram_rdata;

  always_comb begin
    if (slots_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(slots_q) > SLOTS) begin
      n_eff = CNT_W'(SLOTS);
    end else begin
      n_eff = CNT_W'(slots_q);
    end
    for (int i = 0; i < SLOTS; i++) begin
      en_mask[i] = (CNT_W'(i) < n_eff);
    end
  end

  assign free_mask  = ~pend_q & en_mask;
  assign wait_mask  = pend_q & ~run_q & en_mask;
  assign free_found = |free_mask;
  assign free_idx   = lowest_idx(free_mask);
  assign wait_idx   = lowest_idx(wait_mask);
  assign cand_idx   = lowest_idx(scan_q);
  assign free_bit   = {{(SLOTS-1){1'b0}}, 1'b1} << free_idx;
  assign wait_bit   = {{(SLOTS-1){1'b0}}, 1'b1} << wait_idx;
  assign cand_bit   = {{(SLOTS-1){1'b0}}, 1'b1} << cand_idx;
  assign slot_bit   = {{(SLOTS-1){1'b0}}, 1'b1} << slot_q;
  assign pend_cnt   = popcount(pend_q & en_mask);

  assign ram_we    = cmd_i.push & free_found;
  assign ram_re    = cmd_i.assign_job | cmd_i.scan_step;
  assign ram_raddr = cmd_i.assign_job ? wait_idx : cand_idx;

  jsd_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (SLOTS)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx),
    .wdata_i (handle_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.func       = func_e'(func_q);
  assign stat_o.wait_found = |wait_mask;
  assign stat_o.cand_found = |scan_q;
  assign stat_o.match      = (ram_rdata == handle_q);
  assign stat_o.out_free   = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= CFG_W'(16);
      pend_q      <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slots_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        pend_q <= pend_q | free_bit;
        run_q  <= run_q & ~free_bit;
      end else if (cmd_i.assign_job) begin
        run_q <= run_q | wait_bit;
      end else if (cmd_i.match_clear) begin
        pend_q <= pend_q & ~slot_bit;
        run_q  <= run_q & ~slot_bit;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q       <= in_data_i.func;
      handle_q     <= in_data_i.job_handle;
      res_status_q <= STAT_OK;
      slot_q       <= '0;
      assigned_q   <= '0;
    end
    if (cmd_i.push) begin
      if (free_found) begin
        slot_q <= free_idx;
      end else begin
        res_status_q <= STAT_FULL;
      end
    end
    if (cmd_i.assign_job) begin
      slot_q <= wait_idx;
    end
    if (cmd_i.capture) begin
      assigned_q <= ram_rdata;
    end
    if (cmd_i.scan_start) begin
      scan_q <= pend_q & run_q & en_mask;
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_q & ~cand_bit;
      slot_q <= cand_idx;
    end
    if (cmd_i.fail) begin
      slot_q <= '0;
      case (func_e'(func_q))
        FUNC_PUSH:   res_status_q <= STAT_FULL;
        FUNC_ASSIGN: res_status_q <= STAT_NO_JOB;
        default:     res_status_q <= STAT_NOT_FOUND;
      endcase
    end
    if (cmd_i.emit) begin
      out_q.status          <= res_status_q;
      out_q.assigned_handle <= assigned_q;
      out_q.slot_index      <= 4'(slot_q);
      out_q.pending_count   <= 5'(pend_cnt);
      out_q.table_full      <= (pend_cnt == n_eff);
      out_q.more_waiting    <= |wait_mask;
      out_q.all_done        <= (pend_cnt == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/job_slot_dispatch_table.sv =====
// Top level of the job slot dispatch table: controller, datapath and checks.
//
// Input channel in_valid_i/in_ready_o carries one request beat (func, job_handle).
// Output channel out_valid_o/out_ready_i carries one result beat per request.
// One request is in work at a time; in_ready_o is high only while the controller
// is idle, which may overlap a result still waiting in the output register.
// A push goes from IDLE through DECIDE to EMIT; an assign also passes ASG_RD
// (handle RAM registered read); a done scans the running slots, SCAN and CMP
// per slot, and goes to EMIT on a match or from SCAN when none of them matches;
// each comparison is one RAM read and one compare.
// Func code 3 changes nothing.
// The next request is taken the cycle after a result is loaded, so a new request
// is never taken while the previous one is still in work.
// The slot count register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, the block itself does not enforce this. Reset clears
// all pending and running marks, drops any result and sets the slot count to 16;
// the handle RAM is not cleared. A stalled receiver holds the result in the output
// register; the next request is accepted but its result waits in the controller until the register frees.
module job_slot_dispatch_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  jsd_pkg::jsd_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output jsd_pkg::jsd_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [jsd_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import jsd_pkg::*;

  jsd_cmd_t  cmd;
  jsd_stat_t stat;

  jsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  jsd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output register busy");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in work");

  a_full_and_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.table_full && out_data_o.all_done))
    else $error("table reported both full and empty");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != STAT_OK) |->
      (out_data_o.slot_index == '0 && out_data_o.assigned_handle == '0))
    else $error("failed operation reports nonzero slot or handle");
`endif

endmodule
